### hdl/sqd_pkg.sv
// Shared types and constants for the shortest-queue dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package sqd_pkg;

  localparam int unsigned LEN_W = 16;

  localparam logic [LEN_W-1:0] LEN_MAX     = 16'hFFFF;
  localparam logic [LEN_W-1:0] TOTAL_RESET = 16'd6400;

  // Kinds of input item.
  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_SERVE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_RESULT
  } sqd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic emit;
  } sqd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finished;
    logic last;
    logic out_busy;
  } sqd_stat_t;

endpackage

`default_nettype wire

### hdl/sqd_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module sqd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sqd_pkg::sqd_stat_t stat,
  output sqd_pkg::sqd_cmd_t  cmd
);
  import sqd_pkg::*;

  sqd_state_t state_r;
  sqd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // A finished block leaves every counter alone.
        state_nxt = stat.finished ? ST_RESULT : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_RESULT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/sqd_datapath.sv
// Datapath: queue length memory, scan pointer, best-candidate tracking and result register.
`timescale 1ns / 1ps
`default_nettype none

module sqd_datapath #(
  parameter int unsigned NUM_QUEUES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sqd_pkg::sqd_cmd_t  cmd,
  output sqd_pkg::sqd_stat_t stat,
  input  logic               in_action,
  input  logic [2:0]         in_server,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata
);
  import sqd_pkg::*;

  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [QW-1:0] LAST_Q = QW'(NUM_QUEUES - 1);
  localparam logic [6:0]    NQ7    = 7'(NUM_QUEUES);

  // Reduce a server number into the range of queues.
  function automatic logic [QW-1:0] srv_wrap(input logic [2:0] srv);
    logic [6:0] s;
    s = {4'd0, srv};
    for (int k = 0; k < 8; k++) begin
      if (s >= NQ7) begin
        s = s - NQ7;
      end
    end
    return s[QW-1:0];
  endfunction

  logic [LEN_W-1:0]      qlen_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] vld_r;

  logic             action_r;
  logic [QW-1:0]    ptr_r;
  logic [QW-1:0]    cnt_r;
  logic             rd_vld_r;
  logic [QW-1:0]    rd_idx_r;
  logic [LEN_W-1:0] mem_q_r;
  logic             vld_q_r;
  logic [LEN_W-1:0] best_len_r;
  logic [QW-1:0]    best_idx_r;
  logic             have_r;
  logic [LEN_W-1:0] total_r;
  logic [LEN_W-1:0] served_r;
  logic             out_tvalid_r;
  logic [2:0]       out_qi_r;
  logic             out_found_r;
  logic             out_fin_r;
  logic [LEN_W-1:0] out_served_r;

  logic [LEN_W-1:0] rd_data;
  logic             take;
  logic             found_w;
  logic             served_ge;
  logic [LEN_W-1:0] wr_data;
  logic [QW+2:0]    best_idx_ext;

  // Entries never written since reset read as empty.
  assign rd_data = vld_q_r ? mem_q_r : '0;

  // Arrivals keep the strictly shortest queue, so the lowest index wins a tie.
  // Serves keep the first non-empty queue in scan order.
  always_comb begin
    if (action_r == ACT_ARRIVE) begin
      take    = !have_r || (rd_data < best_len_r);
      found_w = have_r && (best_len_r != LEN_MAX);
      wr_data = best_len_r + LEN_W'(1);
    end else begin
      take    = !have_r && (rd_data != '0);
      found_w = have_r;
      wr_data = best_len_r - LEN_W'(1);
    end
  end

  assign served_ge    = served_r >= total_r;
  assign best_idx_ext = {3'b000, best_idx_r};

  assign stat.finished = served_ge;
  assign stat.last     = (cnt_r == LAST_Q);
  assign stat.out_busy = out_tvalid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      served_r     <= '0;
      total_r      <= TOTAL_RESET;
      out_tvalid_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      have_r       <= 1'b0;
    end else begin
      rd_vld_r <= cmd.step;
      if (cfg_we) begin
        total_r <= cfg_data;
      end
      if (cmd.load) begin
        have_r <= 1'b0;
      end else if (rd_vld_r && take) begin
        have_r <= 1'b1;
      end
      if (cmd.commit && found_w) begin
        vld_r[best_idx_r] <= 1'b1;
        if ((action_r == ACT_SERVE) && (served_r != LEN_MAX)) begin
          served_r <= served_r + LEN_W'(1);
        end
      end
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      ptr_r    <= (in_action == ACT_SERVE) ? srv_wrap(in_server) : '0;
      cnt_r    <= '0;
    end else if (cmd.step) begin
      ptr_r <= (ptr_r == LAST_Q) ? '0 : ptr_r + QW'(1);
      cnt_r <= cnt_r + QW'(1);
    end
    rd_idx_r <= ptr_r;
    if (rd_vld_r && take) begin
      best_len_r <= rd_data;
      best_idx_r <= rd_idx_r;
    end
    if (cmd.emit) begin
      out_qi_r     <= found_w ? best_idx_ext[2:0] : 3'b000;
      out_found_r  <= found_w;
      out_fin_r    <= served_ge;
      out_served_r <= served_r;
    end
  end

  // Queue length memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && found_w) begin
      qlen_mem[best_idx_r] <= wr_data;
    end
    mem_q_r <= qlen_mem[ptr_r];
    vld_q_r <= vld_r[ptr_r];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_served_r, out_fin_r, out_found_r, out_qi_r};

endmodule

`default_nettype wire

### hdl/shortest_queue_dispatch_and_serve.sv
// Top level of the join-shortest-queue dispatcher with cyclic work stealing.
//
//   Channel  Direction  Handshake            Payload
//   in       slave      in_tvalid/in_tready  in_tuser = action, in_tdata[2:0] = server_index
//   out      master     out_tvalid/out_tready out_tdata = queue_index, found, finished,
//                                            served_count
//   cfg      slave      cfg_valid/cfg_ready  cfg_data = total_to_serve
//
// An item's scan ends with a last compare and a write-back before its result is loaded:
// the queue lengths sit in a memory with one write port and one registered read port,
// which the scan reads one queue per cycle before the last compare and the write-back.
// A finished block skips the scan and goes straight to its result.
// Reset is synchronous and active low; it clears every queue length through
// per-entry valid bits, clears the served count and loads total_to_serve with 6400.
// The result register lets a new item be accepted while a result waits; a stalled
// output holds the controller in its result state until the register frees up.
// The configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module shortest_queue_dispatch_and_serve #(
  parameter int unsigned NUM_QUEUES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] server_index, [7:3] zero
  input  logic        in_tuser,   // [0] action: 0 arrival, 1 serve request
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] queue_index, [3] found, [4] finished,
                                  // [20:5] served_count, [23:21] zero
  // Configuration write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // total_to_serve
);
  import sqd_pkg::*;

  sqd_cmd_t  cmd;
  sqd_stat_t stat;

  // The threshold register can be written at any cycle.
  assign cfg_ready = 1'b1;

  // The controller walks each item through check, scan, drain, write-back and result, skipping to result when finished.
  sqd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the queue lengths, the served count and the result register.
  sqd_datapath #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (in_tuser),
    .in_server  (in_tdata[2:0]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

### hdl/sqd_checker.sv
// Port-level checks for the dispatcher and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module sqd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Nothing chosen means a zero queue index.
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> out_tdata[2:0] == 3'd0)
    else $error("queue index set without a chosen queue");

  // One item at a time: after an accept the input side closes.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted during processing");

  // Reset leaves no result pending.
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind shortest_queue_dispatch_and_serve sqd_checker u_sqd_checker (.*);

`default_nettype wire
